// File: src/dur_pkg.sv
// Package for the dual UART register model: item, result and state types,
// register addresses, command codes and bit masks.
// No dependencies; used by dur_step and dual_uart_register_model.
package dur_pkg;

	// Event kinds carried by one input beat.
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_PIN   = 2'd2,
		OP_OFFER = 2'd3
	} opcode_t;

	// Register addresses.
	localparam logic [3:0] ADDR_MODE_A = 4'd0;
	localparam logic [3:0] ADDR_STAT_A = 4'd1;
	localparam logic [3:0] ADDR_CMD_A  = 4'd2;
	localparam logic [3:0] ADDR_BUF_A  = 4'd3;
	localparam logic [3:0] ADDR_AUX    = 4'd4;
	localparam logic [3:0] ADDR_IMR    = 4'd5;
	localparam logic [3:0] ADDR_MODE_B = 4'd8;
	localparam logic [3:0] ADDR_STAT_B = 4'd9;
	localparam logic [3:0] ADDR_CMD_B  = 4'd10;
	localparam logic [3:0] ADDR_BUF_B  = 4'd11;
	localparam logic [3:0] ADDR_OPCR   = 4'd13;
	localparam logic [3:0] ADDR_SOPR   = 4'd14;
	localparam logic [3:0] ADDR_ROPR   = 4'd15;

	// Miscellaneous command codes in bits 6:4 of a command write.
	localparam logic [2:0] CMD_RST_PTR = 3'd1;
	localparam logic [2:0] CMD_RST_RX  = 3'd2;
	localparam logic [2:0] CMD_RST_TX  = 3'd3;
	localparam logic [2:0] CMD_CLR_ERR = 3'd4;

	// Local loop mode code in bits 7:6 of the second mode register.
	localparam logic [1:0] MODE_LOCAL_LOOP = 2'd2;

	// Status and interrupt masks.
	localparam logic [7:0] STAT_RXRDY   = 8'h01;
	localparam logic [7:0] STAT_TXRDY   = 8'h04;
	localparam logic [7:0] STAT_TX_BITS = 8'h0c;
	localparam logic [7:0] STAT_ERR     = 8'h70;
	localparam logic [7:0] OPCR_TX_MASK = 8'hc0;
	localparam logic [7:0] OPCR_RX_MASK = 8'h30;
	localparam logic [7:0] ISR_IPC      = 8'h80;
	localparam logic [7:0] PCR_LEVELS   = 8'h0f;
	localparam logic [7:0] PCR_DELTAS   = 8'hf0;
	localparam logic [7:0] PCR_DELTA_0  = 8'h10;

	// One input beat.
	typedef struct packed {
		opcode_t     opcode;
		logic [3:0]  reg_addr;
		logic [7:0]  write_data;
		logic [1:0]  pin_index;
		logic        pin_level;
		logic        rx_port;
		logic [7:0]  rx_char;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic [15:0] read_data;
		logic        tx_valid;
		logic        tx_port;
		logic [7:0]  tx_char;
		logic        char_taken;
		logic        irq;
		logic        out_port_valid;
		logic [7:0]  out_port;
	} result_t;

	// Architectural state of both channels and the shared registers.
	typedef struct packed {
		logic [3:0][7:0] mode_store;
		logic [1:0]      mode_pointer;
		logic [1:0]      rx_enable;
		logic [1:0]      tx_enable;
		logic [1:0][7:0] chan_status;
		logic [1:0][7:0] rx_holding;
		logic [7:0]      int_status;
		logic [7:0]      int_mask;
		logic [7:0]      aux_control;
		logic [7:0]      outport_config;
		logic [3:0]      input_pins;
		logic [7:0]      pin_change;
		logic [7:0]      outport_bits;
		logic            irq_level;
	} state_t;

endpackage

// File: src/dur_step.sv
// Combinational update for one event: next state and the result beat.
// Depends on dur_pkg for the item, result and state types and constants.
module dur_step import dur_pkg::*; (
	input  state_t  st,
	input  item_t   item,
	output state_t  nx,
	output result_t res
);

	logic       ch;
	logic [1:0] midx;
	logic       taken;
	logic       drive;
	logic [7:0] pval;
	logic [3:0] pbit;
	logic [3:0] pnew;

	// Interrupt status bits of each channel.
	function automatic logic [7:0] f_rx_bit(input logic c);
		return c ? 8'h20 : 8'h02;
	endfunction

	function automatic logic [7:0] f_tx_bit(input logic c);
		return c ? 8'h10 : 8'h01;
	endfunction

	// Output port: the top four bits can show interrupt status, then all inverted.
	function automatic logic [7:0] f_port(input state_t s);
		logic [7:0] t;
		t = s.outport_bits;
		if (s.outport_config[7]) t[7] = s.int_status[4];
		if (s.outport_config[6]) t[6] = s.int_status[0];
		if (s.outport_config[5]) t[5] = s.int_status[5];
		if (s.outport_config[4]) t[4] = s.int_status[1];
		return ~t;
	endfunction

	// Receiver status refresh with an optional character offer.
	function automatic state_t f_rx(input state_t s, input logic offer, input logic och,
			input logic [7:0] c, output logic tk);
		state_t r;
		r = s;
		tk = 1'b0;
		for (int i = 0; i < 2; i++) begin
			if (r.rx_enable[i]) begin
				if (!r.chan_status[i][0]) begin
					if (offer && (och == 1'(i))) begin
						r.rx_holding[i] = c;
						r.chan_status[i] = r.chan_status[i] | STAT_RXRDY;
						r.int_status = r.int_status | f_rx_bit(1'(i));
						tk = 1'b1;
					end else begin
						r.int_status = r.int_status & ~f_rx_bit(1'(i));
					end
				end
			end else begin
				r.chan_status[i] = r.chan_status[i] & ~STAT_RXRDY;
				r.int_status = r.int_status & ~f_rx_bit(1'(i));
			end
		end
		r.irq_level = (r.int_status & r.int_mask) != 8'h00;
		return r;
	endfunction

	// Transmitter status refresh from the enable bits.
	function automatic state_t f_tx(input state_t s);
		state_t r;
		r = s;
		for (int i = 0; i < 2; i++) begin
			if (r.tx_enable[i]) begin
				r.chan_status[i] = r.chan_status[i] | STAT_TX_BITS;
				r.int_status = r.int_status | f_tx_bit(1'(i));
			end else begin
				r.chan_status[i] = r.chan_status[i] & ~STAT_TX_BITS;
				r.int_status = r.int_status & ~f_tx_bit(1'(i));
			end
		end
		r.irq_level = (r.int_status & r.int_mask) != 8'h00;
		return r;
	endfunction

	// Event decode and state update, in the order the registers see it.
	always_comb begin
		nx = st;
		res = '0;
		taken = 1'b0;
		drive = 1'b0;
		pval = 8'h00;
		ch = item.reg_addr[3];
		midx = {ch, st.mode_pointer[ch]};
		pbit = 4'b0001 << item.pin_index;
		pnew = (st.input_pins & ~pbit) | (item.pin_level ? pbit : 4'b0000);
		case (item.opcode)
			OP_WRITE: begin
				case (item.reg_addr)
					ADDR_MODE_A, ADDR_MODE_B: begin
						nx.mode_store[midx] = item.write_data;
						nx.mode_pointer[ch] = ~st.mode_pointer[ch];
					end
					ADDR_CMD_A, ADDR_CMD_B: begin
						if (item.write_data[2]) nx.tx_enable[ch] = 1'b1;
						else if (item.write_data[3]) nx.tx_enable[ch] = 1'b0;
						if (item.write_data[0]) nx.rx_enable[ch] = 1'b1;
						else if (item.write_data[1]) nx.rx_enable[ch] = 1'b0;
						case (item.write_data[6:4])
							CMD_RST_PTR: nx.mode_pointer[ch] = 1'b0;
							CMD_RST_RX: begin
								nx.rx_enable[ch] = 1'b0;
								nx.chan_status[ch] = nx.chan_status[ch] & ~STAT_RXRDY;
							end
							CMD_RST_TX: nx.chan_status[ch] = nx.chan_status[ch] & ~STAT_TXRDY;
							CMD_CLR_ERR: nx.chan_status[ch] = nx.chan_status[ch] & ~STAT_ERR;
							default: ;
						endcase
						nx = f_rx(nx, 1'b0, 1'b0, 8'h00, taken);
						if ((nx.outport_config & OPCR_RX_MASK) != 8'h00) begin
							drive = 1'b1;
							pval = f_port(nx);
						end
						nx = f_tx(nx);
						if ((nx.outport_config & OPCR_TX_MASK) != 8'h00) begin
							drive = 1'b1;
							pval = f_port(nx);
						end
					end
					ADDR_BUF_A, ADDR_BUF_B: begin
						if (st.mode_store[{ch, 1'b1}][7:6] == MODE_LOCAL_LOOP) begin
							nx.rx_holding[ch] = item.write_data;
							nx.chan_status[ch] = nx.chan_status[ch] | STAT_RXRDY;
							nx.int_status = nx.int_status | f_rx_bit(ch);
						end else begin
							res.tx_valid = 1'b1;
							res.tx_port = ch;
							res.tx_char = item.write_data;
						end
						nx = f_tx(nx);
						if ((nx.outport_config & OPCR_TX_MASK) != 8'h00) begin
							drive = 1'b1;
							pval = f_port(nx);
						end
					end
					ADDR_AUX: nx.aux_control = item.write_data;
					ADDR_IMR: nx.int_mask = item.write_data;
					ADDR_OPCR: nx.outport_config = item.write_data;
					ADDR_SOPR: begin
						nx.outport_bits = st.outport_bits | item.write_data;
						drive = 1'b1;
						pval = f_port(nx);
					end
					ADDR_ROPR: begin
						nx.outport_bits = st.outport_bits & ~item.write_data;
						drive = 1'b1;
						pval = f_port(nx);
					end
					default: ;
				endcase
			end
			OP_READ: begin
				case (item.reg_addr)
					ADDR_MODE_A, ADDR_MODE_B: begin
						res.read_data = {8'h00, st.mode_store[midx]};
						nx.mode_pointer[ch] = ~st.mode_pointer[ch];
					end
					ADDR_STAT_A, ADDR_STAT_B: res.read_data = {8'h00, st.chan_status[ch]};
					ADDR_BUF_A, ADDR_BUF_B: begin
						res.read_data = {st.chan_status[ch], st.rx_holding[ch]};
						nx.chan_status[ch] = nx.chan_status[ch] & ~STAT_RXRDY;
						nx.int_status = nx.int_status & ~f_rx_bit(ch);
						nx = f_rx(nx, 1'b0, 1'b0, 8'h00, taken);
						if ((nx.outport_config & OPCR_RX_MASK) != 8'h00) begin
							drive = 1'b1;
							pval = f_port(nx);
						end
					end
					ADDR_AUX: begin
						res.read_data = {8'h00, st.pin_change};
						nx.pin_change = st.pin_change & PCR_LEVELS;
						nx.int_status = nx.int_status & ~ISR_IPC;
						nx = f_rx(nx, 1'b0, 1'b0, 8'h00, taken);
						if ((nx.outport_config & OPCR_RX_MASK) != 8'h00) begin
							drive = 1'b1;
							pval = f_port(nx);
						end
					end
					ADDR_IMR: res.read_data = {8'h00, st.int_status};
					ADDR_OPCR: res.read_data = {12'h000, st.input_pins};
					default: ;
				endcase
			end
			OP_PIN: begin
				// A real level change latches the levels and the delta bit.
				if (pnew != st.input_pins) begin
					nx.pin_change = (st.pin_change & PCR_DELTAS) | {4'h0, pnew}
						| (PCR_DELTA_0 << item.pin_index);
					if ((st.aux_control[3:0] & pbit) != 4'h0)
						nx.int_status = nx.int_status | ISR_IPC;
				end
				nx.input_pins = pnew;
			end
			OP_OFFER: begin
				nx = f_rx(st, 1'b1, item.rx_port, item.rx_char, taken);
				if ((nx.outport_config & OPCR_RX_MASK) != 8'h00) begin
					drive = 1'b1;
					pval = f_port(nx);
				end
			end
			default: ;
		endcase
		res.char_taken = taken;
		res.irq = nx.irq_level;
		res.out_port_valid = drive;
		res.out_port = pval;
	end

endmodule

// File: src/dual_uart_register_model.sv
// Top level of the dual UART register model: input stage, state registers
// and output register around the dur_step update logic.
// Depends on dur_pkg and dur_step.
//
//  channel | signals                       | beat content
//  --------+-------------------------------+-----------------------------------
//  input   | in_valid, in_ready, in_data   | one event (item_t)
//  output  | out_valid, out_ready, out_data| one result per event (result_t)
//
// An event is registered in the input stage and its result is then registered
// in the output register; one event is taken every cycle while the output is
// not stalled. The state registers update when the event moves into the
// output register, which is the only loop and sets the one-event-per-cycle rate.
// Reset clears all state and both valid flags. A stalled output holds the
// result and the event behind it, and in_ready stays low until the output drains.
module dual_uart_register_model import dur_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  item_t   in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    s1_valid_q;
	item_t   item_s1;
	state_t  state_q;
	state_t  state_nx;
	result_t res_nx;
	logic    out_valid_q;
	result_t out_data_q;
	logic    advance;

	// An event moves on when the output register is empty or being drained.
	assign advance = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;

	dur_step u_step (
		.st   (state_q),
		.item (item_s1),
		.nx   (state_nx),
		.res  (res_nx)
	);

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// State commits together with the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// A held event in the input stage is never dropped.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q)
		else $error("input stage lost an event");

	// An empty output register always leaves the input open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input blocked with empty output register");

	// A transmit and a taken character never come from the same event.
	a_tx_xor_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q.tx_valid && out_data_q.char_taken))
		else $error("transmit and receive take in one result");

	// Unused transmit and port fields are zero.
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_data_q.tx_valid || (out_data_q.tx_char == 8'h00
			&& !out_data_q.tx_port))
			&& (out_data_q.out_port_valid || out_data_q.out_port == 8'h00)))
		else $error("unused result field not zero");

endmodule
